### sv/motor_feedback_decoder_assert.svh
// Assertion macros for the motor feedback decoder.
// Used by the top level; expects clk and rst_n in scope where expanded.
`ifndef MOTOR_FEEDBACK_DECODER_ASSERT_SVH
`define MOTOR_FEEDBACK_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset
`define MFD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("motor_feedback_decoder: assertion failed");
// Checked at every edge, reset included
`define MFD_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("motor_feedback_decoder: reset assertion failed");
`else
`define MFD_ASSERT(label, prop)
`define MFD_ASSERT_ALWAYS(label, prop)
`endif
`endif

### sv/mfd_pkg.sv
// Shared types, constants and filter arithmetic for the motor feedback decoder.
// No dependencies; used by every module of the block.
`default_nettype none
package mfd_pkg;

  // Field widths
  localparam int TURN_BITS   = 16;
  localparam int ANGLE_W     = 13;
  localparam int WORD_W      = 16;
  localparam int TEMP_W      = 8;
  localparam int PAYLOAD_W   = 64;
  localparam int TURN_OUT_W  = 16;
  localparam int TOTAL_W     = 29;
  localparam int DEGREES_W   = 35;
  localparam int SMOOTH_W    = 24;
  localparam int KIND_W      = 2;
  localparam int COEF_W      = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;

  // Payload byte positions (byte 0 in the top bits)
  localparam int ANGLE_LSB   = 48;
  localparam int SPEED_LSB   = 32;
  localparam int CURRENT_LSB = 16;
  localparam int TEMP_LSB    = 8;

  // Angle unwrap
  localparam logic signed [ANGLE_W:0] HALF_TURN     = (ANGLE_W + 1)'(4096);
  localparam logic signed [ANGLE_W:0] NEG_HALF_TURN = -(ANGLE_W + 1)'(4096);
  localparam logic signed [TURN_BITS-1:0] TURN_MAX = {1'b0, {(TURN_BITS - 1){1'b1}}};
  localparam logic signed [TURN_BITS-1:0] TURN_MIN = {1'b1, {(TURN_BITS - 1){1'b0}}};

  // Degrees: (total - center) * 45, evaluated wide enough before truncation
  localparam int TOTAL_RAW_W = TURN_BITS + ANGLE_W;
  localparam int DEG_CALC_W  = (TURN_BITS + 21 > DEGREES_W) ? TURN_BITS + 21 : DEGREES_W;
  localparam int DEG_SCALE   = 45;

  // IIR filter: accumulator in Q16 stays within the 16-bit sample range
  localparam int ACC_W        = 33;
  localparam int PROD_W       = ACC_W + COEF_W + 2;
  localparam int Q16_SHIFT    = 16;
  localparam int Q16_ROUND    = 32768;
  localparam int SMOOTH_SHIFT = 8;
  localparam int SMOOTH_ROUND = 128;
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(65536);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Output beat packing
  localparam int OUT_FIELDS_W = ANGLE_W + 2 * WORD_W + TEMP_W + TURN_OUT_W + TOTAL_W
                                + DEGREES_W + 2 * SMOOTH_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_KIND    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_COEF    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_COEF  = 2'd3;

  // Motor kinds
  localparam logic [KIND_W-1:0] KIND_SMALL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LARGE = 2'd1;

  // Reset values of the registers
  localparam logic [COEF_W-1:0] COEF_RESET = COEF_W'(16384);

  typedef struct packed {
    logic [KIND_W-1:0]  motor_kind;
    logic [ANGLE_W-1:0] center_offset;
    logic [COEF_W-1:0]  speed_coef;
    logic [COEF_W-1:0]  current_coef;
  } cfg_t;

  // Decoded frame handed from front to back
  typedef struct packed {
    logic [ANGLE_W-1:0]          angle;
    logic signed [WORD_W-1:0]    speed;
    logic signed [WORD_W-1:0]    current;
    logic [TEMP_W-1:0]           temp;
    logic signed [TURN_BITS-1:0] turn;
  } frame_t;

  // Result beat fields
  typedef struct packed {
    logic [ANGLE_W-1:0]           mech_angle;
    logic signed [WORD_W-1:0]     speed_rpm;
    logic signed [WORD_W-1:0]     torque_current;
    logic [TEMP_W-1:0]            temperature;
    logic signed [TURN_OUT_W-1:0] turn_number;
    logic signed [TOTAL_W-1:0]    total_angle;
    logic signed [DEGREES_W-1:0]  degrees_q10;
    logic signed [SMOOTH_W-1:0]   speed_smoothed;
    logic signed [SMOOTH_W-1:0]   current_smoothed;
  } result_t;

  // One IIR step: acc += floor((c * (x * 2^16 - acc) + 2^15) / 2^16)
  function automatic logic signed [ACC_W-1:0] filt_update(
    input logic signed [ACC_W-1:0]  acc,
    input logic signed [WORD_W-1:0] x,
    input logic [COEF_W-1:0]        coef
  );
    logic signed [COEF_W:0]   c;
    logic signed [ACC_W:0]    d;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    c    = (coef > COEF_ONE) ? signed'({1'b0, COEF_ONE}) : signed'({1'b0, coef});
    d    = (ACC_W + 1)'(signed'({x, {Q16_SHIFT{1'b0}}})) - (ACC_W + 1)'(acc);
    prod = PROD_W'(c) * PROD_W'(d);
    rnd  = prod + PROD_W'(Q16_ROUND);
    return acc + ACC_W'(rnd >>> Q16_SHIFT);
  endfunction

  // Q16 accumulator to Q8 output, rounded half up
  function automatic logic signed [SMOOTH_W-1:0] filt_out(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] tmp;
    tmp = acc + ACC_W'(SMOOTH_ROUND);
    return tmp[SMOOTH_SHIFT +: SMOOTH_W];
  endfunction

endpackage
`default_nettype wire

### sv/mfd_front.sv
// Front end: accepts feedback frames, unpacks fields and unwraps the turn count.
// Depends on mfd_pkg; feeds mfd_queue.
`default_nettype none
module mfd_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [mfd_pkg::PAYLOAD_W-1:0]    in_tdata,
  input  wire logic [mfd_pkg::KIND_W-1:0]       motor_kind,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output mfd_pkg::frame_t                       q_frame
);

  logic [mfd_pkg::ANGLE_W-1:0]          prev_angle_r, prev_angle_nxt;
  logic signed [mfd_pkg::TURN_BITS-1:0] turn_r, turn_nxt;
  logic [mfd_pkg::ANGLE_W-1:0]          angle;
  logic signed [mfd_pkg::ANGLE_W:0]     diff;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  // Field unpack
  assign angle = in_tdata[mfd_pkg::ANGLE_LSB +: mfd_pkg::ANGLE_W];
  assign diff  = signed'({1'b0, angle}) - signed'({1'b0, prev_angle_r});

  // Turn unwrap: a jump over half a turn steps the count, saturating
  always_comb begin
    turn_nxt = turn_r;
    if (prev_angle_r != '0) begin
      if (diff > mfd_pkg::HALF_TURN) begin
        if (turn_r != mfd_pkg::TURN_MIN) turn_nxt = turn_r - mfd_pkg::TURN_BITS'(1);
      end else if (diff < mfd_pkg::NEG_HALF_TURN) begin
        if (turn_r != mfd_pkg::TURN_MAX) turn_nxt = turn_r + mfd_pkg::TURN_BITS'(1);
      end
    end
    prev_angle_nxt = angle;
  end

  always_comb begin
    q_frame.angle   = angle;
    q_frame.speed   = in_tdata[mfd_pkg::SPEED_LSB +: mfd_pkg::WORD_W];
    q_frame.current = in_tdata[mfd_pkg::CURRENT_LSB +: mfd_pkg::WORD_W];
    q_frame.temp    = (motor_kind == mfd_pkg::KIND_SMALL) ? '0
                      : in_tdata[mfd_pkg::TEMP_LSB +: mfd_pkg::TEMP_W];
    q_frame.turn    = turn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= '0;
      turn_r       <= '0;
    end else if (q_push) begin
      prev_angle_r <= prev_angle_nxt;
      turn_r       <= turn_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/mfd_queue.sv
// Short FIFO of decoded frames between the front and back ends.
// Depends on mfd_pkg for the frame type and depth.
`default_nettype none
module mfd_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire mfd_pkg::frame_t push_frame,
  output logic             full,
  output logic             q_valid,
  input  wire logic        pop,
  output mfd_pkg::frame_t  pop_frame
);

  mfd_pkg::frame_t               entry_r [mfd_pkg::QUEUE_DEPTH];
  logic [mfd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mfd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mfd_pkg::QCNT_W-1:0]    count_r, count_nxt;
  logic                          do_push, do_pop;

  assign full      = (count_r == mfd_pkg::QCNT_W'(mfd_pkg::QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && q_valid;
  assign pop_frame = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + mfd_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + mfd_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + mfd_pkg::QCNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - mfd_pkg::QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_frame;
  end

endmodule
`default_nettype wire

### sv/mfd_back.sv
// Back end: total angle, degrees, speed and current smoothing, output register.
// Depends on mfd_pkg; pops from mfd_queue.
`default_nettype none
module mfd_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mfd_pkg::cfg_t                cfg,
  input  wire logic                         q_valid,
  input  wire mfd_pkg::frame_t              q_frame,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output mfd_pkg::result_t                  result
);

  logic                                  out_valid_r, out_valid_nxt;
  mfd_pkg::result_t                      res_r, res_nxt;
  logic signed [mfd_pkg::ACC_W-1:0]      speed_acc_r, speed_acc_nxt;
  logic signed [mfd_pkg::ACC_W-1:0]      current_acc_r, current_acc_nxt;
  logic signed [mfd_pkg::TOTAL_RAW_W-1:0] total_raw;
  logic signed [mfd_pkg::DEG_CALC_W-1:0] deg_diff;
  logic signed [mfd_pkg::DEG_CALC_W-1:0] deg_full;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign result    = res_r;

  // Turn count and angle concatenate to the total angle
  assign total_raw = signed'({q_frame.turn, q_frame.angle});
  assign deg_diff  = mfd_pkg::DEG_CALC_W'(total_raw)
                     - mfd_pkg::DEG_CALC_W'(cfg.center_offset);
  assign deg_full  = deg_diff * mfd_pkg::DEG_CALC_W'(mfd_pkg::DEG_SCALE);

  // Filter updates
  always_comb begin
    speed_acc_nxt   = mfd_pkg::filt_update(speed_acc_r, q_frame.speed, cfg.speed_coef);
    current_acc_nxt = mfd_pkg::filt_update(current_acc_r, q_frame.current,
                                           cfg.current_coef);
  end

  // Result beat
  always_comb begin
    res_nxt.mech_angle       = q_frame.angle;
    res_nxt.speed_rpm        = q_frame.speed;
    res_nxt.torque_current   = q_frame.current;
    res_nxt.temperature      = q_frame.temp;
    res_nxt.turn_number      = mfd_pkg::TURN_OUT_W'(q_frame.turn);
    res_nxt.total_angle      = mfd_pkg::TOTAL_W'(total_raw);
    res_nxt.degrees_q10      = mfd_pkg::DEGREES_W'(deg_full);
    res_nxt.speed_smoothed   = mfd_pkg::filt_out(speed_acc_nxt);
    res_nxt.current_smoothed = mfd_pkg::filt_out(current_acc_nxt);
    out_valid_nxt            = q_pop ? 1'b1 : (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      speed_acc_r   <= '0;
      current_acc_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        speed_acc_r   <= speed_acc_nxt;
        current_acc_r <= current_acc_nxt;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

endmodule
`default_nettype wire

### sv/motor_feedback_decoder.sv
// Motor feedback decoder top level: config registers, front, queue, back.
// Depends on mfd_pkg, mfd_front, mfd_queue, mfd_back and the assertion header.
//
// Usage:
//   Input channel (in_*): one beat carries one 8-byte feedback frame, byte 0
//   in tdata[63:56]. Output channel (out_*): one result beat per frame, in
//   order. Configuration (cfg_*): write motor_kind, center_offset, speed_coef
//   and current_coef by index while the block is idle.
//   Path: an accepted frame is written into the queue, then the back end pops
//   it and the output register loads, raising out_tvalid; a held output beat
//   can keep the frame waiting in the queue.
//   Throughput: one frame per cycle while out_tready stays high; the turn
//   count and both filter accumulators each update once per frame.
//   Reset: synchronous, active low; clears turn count, last angle, filter
//   accumulators, queue and output valid; registers return to motor_kind 1,
//   center 0 and both coefficients 16384.
//   Stall: when out_tready is low the output beat holds; the two-entry queue
//   absorbs frames until full, then in_tready drops.
`default_nettype none
`include "motor_feedback_decoder_assert.svh"
module motor_feedback_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // Input: [63:0] rx_payload
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [mfd_pkg::PAYLOAD_W-1:0]     in_tdata,
  // Output, low bit up: mech_angle, speed_rpm, torque_current, temperature,
  // turn_number, total_angle, degrees_q10, speed_smoothed, current_smoothed,
  // zero pad
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [mfd_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Configuration write port
  input  wire logic                              cfg_we,
  input  wire logic [mfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [mfd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mfd_pkg::cfg_t    cfg_r, cfg_nxt;
  mfd_pkg::frame_t  push_frame, pop_frame;
  mfd_pkg::result_t result;
  logic             q_full, q_push, q_pop, q_valid;

  // Configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mfd_pkg::CFG_MOTOR_KIND:    cfg_nxt.motor_kind    = cfg_wdata[mfd_pkg::KIND_W-1:0];
        mfd_pkg::CFG_CENTER_OFFSET: cfg_nxt.center_offset = cfg_wdata[mfd_pkg::ANGLE_W-1:0];
        mfd_pkg::CFG_SPEED_COEF:    cfg_nxt.speed_coef    = cfg_wdata[mfd_pkg::COEF_W-1:0];
        mfd_pkg::CFG_CURRENT_COEF:  cfg_nxt.current_coef  = cfg_wdata[mfd_pkg::COEF_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motor_kind    <= mfd_pkg::KIND_LARGE;
      cfg_r.center_offset <= '0;
      cfg_r.speed_coef    <= mfd_pkg::COEF_RESET;
      cfg_r.current_coef  <= mfd_pkg::COEF_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .motor_kind (cfg_r.motor_kind),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_frame    (push_frame)
  );

  mfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (push_frame),
    .full       (q_full),
    .q_valid    (q_valid),
    .pop        (q_pop),
    .pop_frame  (pop_frame)
  );

  mfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_frame   (pop_frame),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  // Output beat packing, first field in the low bits
  assign out_tdata = {{mfd_pkg::OUT_PAD_W{1'b0}},
                      result.current_smoothed, result.speed_smoothed,
                      result.degrees_q10, result.total_angle, result.turn_number,
                      result.temperature, result.torque_current, result.speed_rpm,
                      result.mech_angle};

  // Reset leaves no result beat pending
  `MFD_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid)
  // A full queue only happens behind a held output beat
  `MFD_ASSERT(a_full_means_out_held, !in_tready |-> out_tvalid)
  // A new result beat only comes from a queued frame
  `MFD_ASSERT(a_out_from_queue, $rose(out_tvalid) |-> $past(q_valid))

endmodule
`default_nettype wire
